// ===== rtl/hla_pkg.sv =====
// ----------------------------------------------------------------------------
// hla_pkg
// Shared types, constants and the sine table for the hough line accumulator.
// ----------------------------------------------------------------------------
package hla_pkg;

  localparam int unsigned MAX_DIM    = 512;
  localparam int unsigned RHO_BINS   = 1448;
  localparam int unsigned ANGLE_BINS = 180;
  localparam int unsigned COUNT_W    = 20;
  localparam int unsigned ACC_DEPTH  = RHO_BINS * ANGLE_BINS;
  localparam int unsigned ADDR_W     = $clog2(ACC_DEPTH);
  localparam int unsigned EDGE_MIN   = 240;
  localparam int unsigned BORDER     = 5;
  localparam int unsigned WIN_RHO    = 5;
  localparam int unsigned WIN_ANG    = 15;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    CMD_VOTE  = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_OFFSET    = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  pix_x;
    logic [8:0]  pix_y;
    logic [7:0]  magnitude;
    logic [10:0] rho_index;
    logic [7:0]  angle;
  } in_item_t;

  typedef struct packed {
    logic [19:0] votes;
    logic        is_peak;
    logic        accepted;
    logic [7:0]  dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_MUL,
    OP_ROW,
    OP_ADR,
    OP_WR,
    OP_CENTER,
    OP_CVAL,
    OP_SCAN,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       pix_ok;
    logic       chk_ok;
    logic       clr_last;
    logic       angle_last;
    logic       scan_last;
    logic       out_full;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_V_MUL,
    S_V_ROW,
    S_V_ADR,
    S_V_RD,
    S_V_WR,
    S_C_CTR,
    S_C_RD,
    S_C_VAL,
    S_C_SCAN,
    S_C_DRN1,
    S_C_DRN2,
    S_RESULT
  } state_e;

  typedef logic [16:0] sin_rom_t [0:90];

  // round(65536*sin(d deg)) by a q30 taylor series
  function automatic logic [16:0] sin_q16(input int unsigned d);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] rnd;
    th   = (64'(d) * PI_Q30) / 64'd180;
    th2  = (th * th) >> 30;
    term = th;
    sum  = '0;
    for (int k = 0; k < 12; k++) begin
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
      term = ((term * th2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
    end
    if (sum < 0) begin
      sum = '0;
    end
    rnd = ($unsigned(sum) + 64'd8192) >> 14;
    return rnd[16:0];
  endfunction

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t r;
    for (int d = 0; d <= 90; d++) begin
      r[d] = sin_q16(d);
    end
    return r;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// ===== rtl/hla_ctrl.sv =====
// ----------------------------------------------------------------------------
// hla_ctrl
// Sequencer for vote, check and clear transactions and the reset clear pass.
// ----------------------------------------------------------------------------
module hla_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hla_pkg::dp_sts_t sts_i,
  output hla_pkg::dp_ctl_t ctl_o
);

  hla_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hla_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o.op   = hla_pkg::OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      hla_pkg::S_INIT: begin
        ctl_o.op = hla_pkg::OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = hla_pkg::S_IDLE;
        end
      end
      hla_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.op = hla_pkg::OP_CAPTURE;
          state_d  = hla_pkg::S_DECODE;
        end
      end
      hla_pkg::S_DECODE: begin
        if (sts_i.cmd == hla_pkg::CMD_VOTE && sts_i.pix_ok) begin
          state_d = hla_pkg::S_V_MUL;
        end else if (sts_i.cmd == hla_pkg::CMD_CHECK && sts_i.chk_ok) begin
          state_d = hla_pkg::S_C_CTR;
        end else if (sts_i.cmd == hla_pkg::CMD_CLEAR) begin
          state_d = hla_pkg::S_CLEAR;
        end else begin
          state_d = hla_pkg::S_RESULT;
        end
      end
      hla_pkg::S_CLEAR: begin
        ctl_o.op = hla_pkg::OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = hla_pkg::S_RESULT;
        end
      end
      hla_pkg::S_V_MUL: begin
        ctl_o.op = hla_pkg::OP_MUL;
        state_d  = hla_pkg::S_V_ROW;
      end
      hla_pkg::S_V_ROW: begin
        ctl_o.op = hla_pkg::OP_ROW;
        state_d  = hla_pkg::S_V_ADR;
      end
      hla_pkg::S_V_ADR: begin
        ctl_o.op = hla_pkg::OP_ADR;
        state_d  = hla_pkg::S_V_RD;
      end
      hla_pkg::S_V_RD: begin
        state_d = hla_pkg::S_V_WR;
      end
      hla_pkg::S_V_WR: begin
        ctl_o.op = hla_pkg::OP_WR;
        state_d  = sts_i.angle_last ? hla_pkg::S_RESULT : hla_pkg::S_V_MUL;
      end
      hla_pkg::S_C_CTR: begin
        ctl_o.op = hla_pkg::OP_CENTER;
        state_d  = hla_pkg::S_C_RD;
      end
      hla_pkg::S_C_RD: begin
        state_d = hla_pkg::S_C_VAL;
      end
      hla_pkg::S_C_VAL: begin
        ctl_o.op = hla_pkg::OP_CVAL;
        state_d  = hla_pkg::S_C_SCAN;
      end
      hla_pkg::S_C_SCAN: begin
        ctl_o.op = hla_pkg::OP_SCAN;
        if (sts_i.scan_last) begin
          state_d = hla_pkg::S_C_DRN1;
        end
      end
      hla_pkg::S_C_DRN1: begin
        state_d = hla_pkg::S_C_DRN2;
      end
      hla_pkg::S_C_DRN2: begin
        state_d = hla_pkg::S_RESULT;
      end
      hla_pkg::S_RESULT: begin
        if (!sts_i.out_full) begin
          ctl_o.op = hla_pkg::OP_RESULT;
          state_d  = hla_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hla_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hla_dp.sv =====
// ----------------------------------------------------------------------------
// hla_dp
// Datapath: config registers, rho arithmetic, accumulator memory, window scan
// and the output register.
// ----------------------------------------------------------------------------
module hla_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hla_pkg::dp_ctl_t  ctl_i,
  output hla_pkg::dp_sts_t  sts_o,
  input  hla_pkg::in_item_t in_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [19:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hla_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = hla_pkg::ADDR_W;
  localparam int unsigned CW = hla_pkg::COUNT_W;

  // config
  logic [9:0]  width_q, height_q, offset_q;
  logic [19:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd512;
      height_q <= 10'd512;
      offset_q <= 10'd724;
      thr_q    <= 20'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hla_pkg::REG_WIDTH:     width_q  <= cfg_data_i[9:0];
        hla_pkg::REG_HEIGHT:    height_q <= cfg_data_i[9:0];
        hla_pkg::REG_OFFSET:    offset_q <= cfg_data_i[9:0];
        hla_pkg::REG_THRESHOLD: thr_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic [10:0] rows;
  logic [9:0]  w_eff, h_eff;
  always_comb begin
    rows  = ({offset_q, 1'b0} < 11'(hla_pkg::RHO_BINS)) ? {offset_q, 1'b0}
                                                        : 11'(hla_pkg::RHO_BINS);
    w_eff = (width_q > 10'(hla_pkg::MAX_DIM)) ? 10'(hla_pkg::MAX_DIM) : width_q;
    h_eff = (height_q > 10'(hla_pkg::MAX_DIM)) ? 10'(hla_pkg::MAX_DIM) : height_q;
  end

  // item and working registers
  hla_pkg::in_item_t in_q, in_d;
  logic [7:0]    t_q, t_d;
  logic [7:0]    drop_q, drop_d;
  logic [25:0]   px_q, px_d, py_q, py_d;
  logic          cneg_q, cneg_d;
  logic [10:0]   row_q, row_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] val_q, val_d;
  logic [3:0]    di_q, di_d;
  logic [4:0]    dj_q, dj_d;
  logic          sok1_q, sok1_d, sok2_q;
  logic          greater_q, greater_d;
  logic          outv_q, outv_d;
  hla_pkg::out_item_t out_q, out_d;

  // memory
  logic [CW-1:0] mem [0:hla_pkg::ACC_DEPTH-1];
  logic [CW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

  // status
  logic pix_ok, chk_ok;
  always_comb begin
    pix_ok = (in_q.command == hla_pkg::CMD_VOTE)
          && (in_q.pix_x >= 9'(hla_pkg::BORDER))
          && ((10'(in_q.pix_x) + 10'(hla_pkg::BORDER)) < w_eff)
          && (in_q.pix_y >= 9'(hla_pkg::BORDER))
          && ((10'(in_q.pix_y) + 10'(hla_pkg::BORDER)) < h_eff)
          && (in_q.magnitude > 8'(hla_pkg::EDGE_MIN));
    chk_ok = (in_q.command == hla_pkg::CMD_CHECK)
          && (in_q.rho_index < rows)
          && (in_q.angle < 8'(hla_pkg::ANGLE_BINS));
  end

  assign sts_o.cmd        = in_q.command;
  assign sts_o.pix_ok     = pix_ok;
  assign sts_o.chk_ok     = chk_ok;
  assign sts_o.clr_last   = (clr_q == AW'(hla_pkg::ACC_DEPTH - 1));
  assign sts_o.angle_last = (t_q == 8'(hla_pkg::ANGLE_BINS - 1));
  assign sts_o.scan_last  = (di_q == 4'(2 * hla_pkg::WIN_RHO))
                         && (dj_q == 5'(2 * hla_pkg::WIN_ANG));
  assign sts_o.out_full   = outv_q && out_stall_i;

  // angle lookups
  logic [6:0]  sin_idx, cos_idx;
  logic [7:0]  col;
  always_comb begin
    if (t_q <= 8'd90) begin
      sin_idx = t_q[6:0];
      cos_idx = 7'(8'd90 - t_q);
    end else begin
      sin_idx = 7'(8'd180 - t_q);
      cos_idx = 7'(t_q - 8'd90);
    end
    if (t_q >= 8'd89 && t_q <= 8'd91) begin
      col = 8'd90;
    end else if (t_q < 8'd2 || t_q == 8'd179) begin
      col = 8'd0;
    end else begin
      col = t_q;
    end
  end

  // rho arithmetic
  logic [27:0] vsum, vmag;
  logic [11:0] rq;
  logic [12:0] rho, row13;
  always_comb begin
    vsum  = cneg_q ? ({2'b00, px_q} - {2'b00, py_q}) : ({2'b00, px_q} + {2'b00, py_q});
    vmag  = vsum[27] ? (28'd0 - vsum) : vsum;
    rq    = vmag[27:16];
    rho   = vsum[27] ? (13'd0 - {1'b0, rq}) : {1'b0, rq};
    row13 = rho + {3'b000, offset_q};
  end

  // window cell
  logic [12:0] ci;
  logic [9:0]  cj;
  logic        cell_ok;
  always_comb begin
    ci = {2'b00, in_q.rho_index} + {9'd0, di_q} - 13'(hla_pkg::WIN_RHO);
    cj = {2'b00, in_q.angle} + {5'd0, dj_q} - 10'(hla_pkg::WIN_ANG);
    cell_ok = !ci[12] && (ci[11:0] < {1'b0, rows})
           && !cj[9] && (cj[8:0] < 9'(hla_pkg::ANGLE_BINS));
  end

  always_comb begin
    in_d      = in_q;
    t_d       = t_q;
    drop_d    = drop_q;
    px_d      = px_q;
    py_d      = py_q;
    cneg_d    = cneg_q;
    row_d     = row_q;
    hit_d     = hit_q;
    addr_d    = addr_q;
    clr_d     = clr_q;
    val_d     = val_q;
    di_d      = di_q;
    dj_d      = dj_q;
    sok1_d    = 1'b0;
    greater_d = greater_q;
    outv_d    = outv_q && out_stall_i;
    out_d     = out_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = '0;
    if (sok2_q && (rdata_q > val_q)) begin
      greater_d = 1'b1;
    end
    case (ctl_i.op)
      hla_pkg::OP_CAPTURE: begin
        in_d      = in_data_i;
        t_d       = '0;
        drop_d    = '0;
        clr_d     = '0;
        di_d      = '0;
        dj_d      = '0;
        val_d     = '0;
        greater_d = 1'b0;
      end
      hla_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      hla_pkg::OP_MUL: begin
        px_d   = 26'(in_q.pix_x) * 26'(hla_pkg::SIN_ROM[sin_idx]);
        py_d   = 26'(in_q.pix_y) * 26'(hla_pkg::SIN_ROM[cos_idx]);
        cneg_d = (t_q > 8'd90);
      end
      hla_pkg::OP_ROW: begin
        row_d = row13[10:0];
        hit_d = !row13[12] && (row13[11:0] < {1'b0, rows});
      end
      hla_pkg::OP_ADR: begin
        addr_d = AW'(row_q) * AW'(hla_pkg::ANGLE_BINS) + AW'(col);
      end
      hla_pkg::OP_WR: begin
        if (hit_q) begin
          we    = 1'b1;
          wdata = (rdata_q == '1) ? rdata_q : rdata_q + CW'(1);
        end else begin
          drop_d = drop_q + 8'd1;
        end
        t_d = t_q + 8'd1;
      end
      hla_pkg::OP_CENTER: begin
        addr_d = AW'(in_q.rho_index) * AW'(hla_pkg::ANGLE_BINS) + AW'(in_q.angle);
      end
      hla_pkg::OP_CVAL: begin
        val_d = rdata_q;
      end
      hla_pkg::OP_SCAN: begin
        addr_d = AW'(ci[10:0]) * AW'(hla_pkg::ANGLE_BINS) + AW'(cj[7:0]);
        sok1_d = cell_ok;
        if (dj_q == 5'(2 * hla_pkg::WIN_ANG)) begin
          dj_d = '0;
          di_d = di_q + 4'd1;
        end else begin
          dj_d = dj_q + 5'd1;
        end
      end
      hla_pkg::OP_RESULT: begin
        outv_d         = 1'b1;
        out_d.votes    = chk_ok ? val_q : '0;
        out_d.is_peak  = chk_ok && (val_q > thr_q) && !greater_q;
        out_d.accepted = pix_ok;
        out_d.dropped  = pix_ok ? drop_q : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      sok1_q <= 1'b0;
      sok2_q <= 1'b0;
      outv_q <= 1'b0;
    end else begin
      clr_q  <= clr_d;
      sok1_q <= sok1_d;
      sok2_q <= sok1_q;
      outv_q <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    t_q       <= t_d;
    drop_q    <= drop_d;
    px_q      <= px_d;
    py_q      <= py_d;
    cneg_q    <= cneg_d;
    row_q     <= row_d;
    hit_q     <= hit_d;
    addr_q    <= addr_d;
    val_q     <= val_d;
    di_q      <= di_d;
    dj_q      <= dj_d;
    greater_q <= greater_d;
    out_q     <= out_d;
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/hough_line_accumulator.sv =====
// ----------------------------------------------------------------------------
// hough_line_accumulator
// Hough line voting into a 1448 x 180 counter store with windowed peak checks.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   hla_pkg::in_item_t
//   out      output     out_valid / out_stall hla_pkg::out_item_t
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// vote: per angle, the multiply, row, address, read and write states run in turn;
// the write finishes a read-modify-write of the accumulator; a rejected pixel skips voting.
// check: one window cell read per cycle (11 x 31 cells).
// clear: one entry written per cycle.
// after reset a clearing pass runs with in_stall high.
// one transaction at a time; a result waits in the output register under stall.
// ----------------------------------------------------------------------------
module hough_line_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hla_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hla_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i
);

  hla_pkg::dp_ctl_t ctl;
  hla_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  hla_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/hla_checker.sv =====
// ----------------------------------------------------------------------------
// hla_checker
// Port-level checks for the hough line accumulator.
// ----------------------------------------------------------------------------
module hla_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hla_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_peak |-> out_data_o.votes != 20'd0 && !out_data_o.accepted)
    else $error("peak flag inconsistent");

endmodule

bind hough_line_accumulator hla_checker u_hla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
